### hdl/masked_grid_extract_min_unit_defines.svh
// Assertion macros shared by the checker of the tile grid minimum extractor.
// No dependencies; include by bare file name.
`ifndef MASKED_GRID_EXTRACT_MIN_UNIT_DEFINES_SVH
`define MASKED_GRID_EXTRACT_MIN_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MGEM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MGEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mgem_pkg.sv
// Shared types, codes and constants of the tile grid minimum extractor.
// No dependencies; compile first.
`timescale 1ns / 1ps

package mgem_pkg;

	// Default grid geometry
	localparam int GRID_ROWS_DEF    = 18;
	localparam int GRID_COLUMNS_DEF = 16;
	localparam int GRID_LEVELS_DEF  = 2;

	// Fixed field widths
	localparam int COUNT_W     = 10;
	localparam int REG_W       = 5;
	localparam int REG_INDEX_W = 2;
	localparam int KEY_W       = 32;

	// Register indexes
	localparam logic [REG_INDEX_W-1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [REG_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd1;

	localparam logic [REG_W-1:0] MAP_WIDTH_RESET  = 5'd16;
	localparam logic [REG_W-1:0] MAP_HEIGHT_RESET = 5'd18;

	// Request modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TAKE = 1'b1;

	typedef struct packed {
		logic               mode;
		logic               tile_level;
		logic [4:0]         tile_row;
		logic [3:0]         tile_column;
		logic               tile_movable;
		logic signed [15:0] tile_rank;
		logic [15:0]        tile_nearness;
	} request_t;

	typedef struct packed {
		logic               chosen_level;
		logic [4:0]         chosen_row;
		logic [3:0]         chosen_column;
		logic [COUNT_W-1:0] remaining_count;
		logic               grid_empty;
	} result_t;

	typedef struct packed {
		logic [REG_INDEX_W-1:0] index;
		logic [REG_W-1:0]       data;
	} regs_write_t;

	// Strobes towards the tile store
	typedef struct packed {
		logic row_rd;
		logic row_wr;
		logic key_rd;
		logic key_wr;
	} store_ctrl_t;

	// Strobes towards the compare unit
	typedef struct packed {
		logic clear;
		logic cand_valid;
	} scan_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_SCAN_ROW,
		ST_SCAN_COLS,
		ST_SCAN_DRAIN,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_FINISH
	} state_t;

	// Address width for a depth, at least one bit
	function automatic int width_of(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

### hdl/mgem_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is given by the instantiating scope; no other dependencies.
`timescale 1ns / 1ps

interface mgem_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/masked_grid_extract_min_unit.sv
// Tile grid minimum extractor, top level: request sequencer, count and result register.
// Depends on mgem_pkg, mgem_chan_if, mgem_tile_store and mgem_scan_unit.
`timescale 1ns / 1ps

// A load request writes one tile's movable bit, rank and nearness and returns
// nothing; after acceptance it holds the request channel through a mask read
// and a write, unless its coordinates lie outside the grid. A take request scans
// the movable tiles within the configured width w and height h (each clamped
// to the grid), level by level, row by row, column by column, through one
// key-memory read port and one comparator: each row costs one mask read plus w
// key reads, and the request channel stays busy until the result is registered.
// The lowest key rank*65536+nearness wins, a later tile
// wins a tie; the winner's movable bit is cleared and the count decremented.
// A take on an empty area returns grid_empty with zero coordinates and changes
// nothing. The result sits in an output register until taken. Per-row valid
// bits clear the movable masks at reset, so no clearing pass is needed.
module masked_grid_extract_min_unit #(
	parameter int GRID_ROWS    = mgem_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = mgem_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_LEVELS  = mgem_pkg::GRID_LEVELS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mgem_chan_if.sink   request,
	mgem_chan_if.source response,
	mgem_chan_if.sink   regs
);
	import mgem_pkg::*;

	localparam int ROW_COUNT  = GRID_LEVELS * GRID_ROWS;
	localparam int TILE_COUNT = ROW_COUNT * GRID_COLUMNS;
	localparam int LVL_W      = width_of(GRID_LEVELS);
	localparam int ROW_W      = width_of(GRID_ROWS);
	localparam int COL_W      = width_of(GRID_COLUMNS);
	localparam int RA_W       = width_of(ROW_COUNT);
	localparam int TA_W       = width_of(TILE_COUNT);

	state_t             state_q, state_d;
	request_t           req_q;
	logic [REG_W-1:0]   map_width_q, map_height_q;
	logic [REG_W-1:0]   w_eff, h_eff;
	logic [COUNT_W-1:0] count_q;

	logic [LVL_W-1:0] lvl_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             last_col, last_row, last_lvl;

	logic             cand_valid_s1;
	logic [LVL_W-1:0] lvl_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;

	logic             req_accept;
	logic             in_range;
	logic             scan_empty;
	logic             slot_free;
	logic [LVL_W-1:0] req_lvl;
	logic [ROW_W-1:0] req_row;
	logic [COL_W-1:0] req_col;

	store_ctrl_t             st_ctrl;
	logic [RA_W-1:0]         row_addr;
	logic [GRID_COLUMNS-1:0] row_wr_data, row_rd_data;
	logic [TA_W-1:0]         key_addr;
	logic [KEY_W-1:0]        key_rd_data;

	scan_ctrl_t       sc_ctrl;
	logic             found;
	logic [LVL_W-1:0] best_lvl;
	logic [ROW_W-1:0] best_row;
	logic [COL_W-1:0] best_col;

	logic    resp_valid_q;
	result_t resp_q;

	function automatic int row_index(input int l, input int r);
		return l * GRID_ROWS + r;
	endfunction

	// Request decode
	assign req_accept = request.valid && request.ready;
	assign in_range   = (int'(request.payload.tile_level) < GRID_LEVELS) &&
		(int'(request.payload.tile_row) < GRID_ROWS) &&
		(int'(request.payload.tile_column) < GRID_COLUMNS);
	assign req_lvl    = LVL_W'(req_q.tile_level);
	assign req_row    = ROW_W'(req_q.tile_row);
	assign req_col    = COL_W'(req_q.tile_column);

	// Clamp the scan area to the grid
	assign w_eff      = (int'(map_width_q) < GRID_COLUMNS) ? map_width_q : REG_W'(GRID_COLUMNS);
	assign h_eff      = (int'(map_height_q) < GRID_ROWS) ? map_height_q : REG_W'(GRID_ROWS);
	assign scan_empty = (w_eff == '0) || (h_eff == '0);
	assign last_col   = int'(col_q) == int'(w_eff) - 1;
	assign last_row   = int'(row_q) == int'(h_eff) - 1;
	assign last_lvl   = int'(lvl_q) == GRID_LEVELS - 1;
	assign slot_free  = !resp_valid_q || response.ready;

	// Configuration writes
	assign regs.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RESET;
			map_height_q <= MAP_HEIGHT_RESET;
		end else if (regs.valid) begin
			case (regs.payload.index)
				REG_MAP_WIDTH:  map_width_q  <= regs.payload.data;
				REG_MAP_HEIGHT: map_height_q <= regs.payload.data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					if (request.payload.mode == MODE_TAKE) begin
						state_d = scan_empty ? ST_CLR_RD : ST_SCAN_ROW;
					end else if (in_range) begin
						state_d = ST_LOAD_RD;
					end
				end
			end
			ST_LOAD_RD:    state_d = ST_LOAD_WR;
			ST_LOAD_WR:    state_d = ST_IDLE;
			ST_SCAN_ROW:   state_d = ST_SCAN_COLS;
			ST_SCAN_COLS: begin
				if (last_col) begin
					state_d = (last_row && last_lvl) ? ST_SCAN_DRAIN : ST_SCAN_ROW;
				end
			end
			ST_SCAN_DRAIN: state_d = ST_CLR_RD;
			ST_CLR_RD:     state_d = found ? ST_CLR_WR : ST_FINISH;
			ST_CLR_WR:     state_d = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Strobes and address selection per state
	always_comb begin
		st_ctrl            = '0;
		sc_ctrl.clear      = 1'b0;
		sc_ctrl.cand_valid = cand_valid_s1;
		request.ready      = 1'b0;
		row_addr      = RA_W'(row_index(int'(lvl_q), int'(row_q)));
		key_addr      = TA_W'(row_index(int'(lvl_q), int'(row_q)) * GRID_COLUMNS + int'(col_q));
		row_wr_data   = row_rd_data;
		case (state_q)
			ST_IDLE: begin
				request.ready = 1'b1;
				sc_ctrl.clear = req_accept && (request.payload.mode == MODE_TAKE);
			end
			ST_LOAD_RD: begin
				st_ctrl.row_rd = 1'b1;
				row_addr       = RA_W'(row_index(int'(req_lvl), int'(req_row)));
			end
			ST_LOAD_WR: begin
				st_ctrl.row_wr       = 1'b1;
				st_ctrl.key_wr       = 1'b1;
				row_addr             = RA_W'(row_index(int'(req_lvl), int'(req_row)));
				key_addr             = TA_W'(row_index(int'(req_lvl), int'(req_row)) *
					GRID_COLUMNS + int'(req_col));
				row_wr_data[req_col] = req_q.tile_movable;
			end
			ST_SCAN_ROW: begin
				st_ctrl.row_rd = 1'b1;
			end
			ST_SCAN_COLS: begin
				st_ctrl.key_rd = 1'b1;
			end
			ST_CLR_RD: begin
				st_ctrl.row_rd = 1'b1;
				row_addr       = RA_W'(row_index(int'(best_lvl), int'(best_row)));
			end
			ST_CLR_WR: begin
				st_ctrl.row_wr        = 1'b1;
				row_addr              = RA_W'(row_index(int'(best_lvl), int'(best_row)));
				row_wr_data[best_col] = 1'b0;
			end
			default: ;
		endcase
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= request.payload;
		end
	end

	// Advance the scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (sc_ctrl.clear) begin
			lvl_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (state_q == ST_SCAN_COLS) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
					lvl_q <= last_lvl ? '0 : lvl_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Candidate stage, aligned with the key read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid_s1 <= 1'b0;
		end else begin
			cand_valid_s1 <= (state_q == ST_SCAN_COLS) && row_rd_data[col_q];
		end
	end

	always_ff @(posedge clk) begin
		lvl_s1 <= lvl_q;
		row_s1 <= row_q;
		col_s1 <= col_q;
	end

	// Track the movable tile count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_LOAD_WR) begin
			if (req_q.tile_movable && !row_rd_data[req_col]) begin
				count_q <= count_q + 1'b1;
			end else if (!req_q.tile_movable && row_rd_data[req_col]) begin
				count_q <= count_q - 1'b1;
			end
		end else if (state_q == ST_CLR_WR) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && slot_free) begin
			resp_valid_q <= 1'b1;
		end else if (response.ready) begin
			resp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && slot_free) begin
			resp_q.chosen_level    <= found ? 1'(best_lvl) : 1'b0;
			resp_q.chosen_row      <= found ? 5'(best_row) : 5'd0;
			resp_q.chosen_column   <= found ? 4'(best_col) : 4'd0;
			resp_q.remaining_count <= count_q;
			resp_q.grid_empty      <= !found;
		end
	end

	assign response.valid   = resp_valid_q;
	assign response.payload = resp_q;

	mgem_tile_store #(
		.GRID_ROWS   (GRID_ROWS),
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_LEVELS (GRID_LEVELS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (st_ctrl),
		.row_addr   (row_addr),
		.row_wr_data(row_wr_data),
		.row_rd_data(row_rd_data),
		.key_addr   (key_addr),
		.key_wr_data({req_q.tile_rank, req_q.tile_nearness}),
		.key_rd_data(key_rd_data)
	);

	mgem_scan_unit #(
		.GRID_ROWS   (GRID_ROWS),
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_LEVELS (GRID_LEVELS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sc_ctrl),
		.cand_key(key_rd_data),
		.cand_lvl(lvl_s1),
		.cand_row(row_s1),
		.cand_col(col_s1),
		.found   (found),
		.best_lvl(best_lvl),
		.best_row(best_row),
		.best_col(best_col)
	);

endmodule

### hdl/mgem_tile_store.sv
// Tile storage: row movable masks with per-row valid bits, and the key memory.
// Depends on mgem_pkg.
`timescale 1ns / 1ps

module mgem_tile_store #(
	parameter int GRID_ROWS    = mgem_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = mgem_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_LEVELS  = mgem_pkg::GRID_LEVELS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  mgem_pkg::store_ctrl_t                                 ctrl,
	input  logic [mgem_pkg::width_of(GRID_LEVELS*GRID_ROWS)-1:0]  row_addr,
	input  logic [GRID_COLUMNS-1:0]                               row_wr_data,
	output logic [GRID_COLUMNS-1:0]                               row_rd_data,
	input  logic [mgem_pkg::width_of(GRID_LEVELS*GRID_ROWS*GRID_COLUMNS)-1:0] key_addr,
	input  logic [mgem_pkg::KEY_W-1:0]                            key_wr_data,
	output logic [mgem_pkg::KEY_W-1:0]                            key_rd_data
);
	import mgem_pkg::*;

	localparam int ROW_COUNT  = GRID_LEVELS * GRID_ROWS;
	localparam int TILE_COUNT = ROW_COUNT * GRID_COLUMNS;

	logic [GRID_COLUMNS-1:0] mask_mem [ROW_COUNT];
	logic [KEY_W-1:0]        key_mem [TILE_COUNT];
	logic [ROW_COUNT-1:0]    row_valid_q;
	logic [GRID_COLUMNS-1:0] row_data_q;
	logic                    row_hit_q;
	logic [KEY_W-1:0]        key_data_q;

	// Mark a row as written; unwritten rows read as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_hit_q   <= 1'b0;
		end else begin
			if (ctrl.row_wr) begin
				row_valid_q[row_addr] <= 1'b1;
			end
			if (ctrl.row_rd) begin
				row_hit_q <= row_valid_q[row_addr];
			end
		end
	end

	// Mask memory, registered read, data held between reads
	always_ff @(posedge clk) begin
		if (ctrl.row_wr) begin
			mask_mem[row_addr] <= row_wr_data;
		end
		if (ctrl.row_rd) begin
			row_data_q <= mask_mem[row_addr];
		end
	end

	// Key memory, registered read
	always_ff @(posedge clk) begin
		if (ctrl.key_wr) begin
			key_mem[key_addr] <= key_wr_data;
		end
		if (ctrl.key_rd) begin
			key_data_q <= key_mem[key_addr];
		end
	end

	assign row_rd_data = row_hit_q ? row_data_q : '0;
	assign key_rd_data = key_data_q;

endmodule

### hdl/mgem_scan_unit.sv
// Shared compare unit: keeps the lowest key seen and its coordinates.
// Depends on mgem_pkg.
`timescale 1ns / 1ps

module mgem_scan_unit #(
	parameter int GRID_ROWS    = mgem_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLUMNS = mgem_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_LEVELS  = mgem_pkg::GRID_LEVELS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  mgem_pkg::scan_ctrl_t                          ctrl,
	input  logic [mgem_pkg::KEY_W-1:0]                    cand_key,
	input  logic [mgem_pkg::width_of(GRID_LEVELS)-1:0]    cand_lvl,
	input  logic [mgem_pkg::width_of(GRID_ROWS)-1:0]      cand_row,
	input  logic [mgem_pkg::width_of(GRID_COLUMNS)-1:0]   cand_col,
	output logic                                          found,
	output logic [mgem_pkg::width_of(GRID_LEVELS)-1:0]    best_lvl,
	output logic [mgem_pkg::width_of(GRID_ROWS)-1:0]      best_row,
	output logic [mgem_pkg::width_of(GRID_COLUMNS)-1:0]   best_col
);
	import mgem_pkg::*;

	localparam int LVL_W = width_of(GRID_LEVELS);
	localparam int ROW_W = width_of(GRID_ROWS);
	localparam int COL_W = width_of(GRID_COLUMNS);

	logic             found_q;
	logic [KEY_W-1:0] best_key_q;
	logic [LVL_W-1:0] best_lvl_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_col_q;
	logic             take_cand;

	// A later candidate wins a tie
	assign take_cand = ctrl.cand_valid &&
		(!found_q || ($signed(cand_key) <= $signed(best_key_q)));

	// Clear at the start of a scan, otherwise track the minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take_cand) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctrl.clear && take_cand) begin
			best_key_q <= cand_key;
			best_lvl_q <= cand_lvl;
			best_row_q <= cand_row;
			best_col_q <= cand_col;
		end
	end

	assign found    = found_q;
	assign best_lvl = best_lvl_q;
	assign best_row = best_row_q;
	assign best_col = best_col_q;

endmodule

### hdl/mgem_checker.sv
// Port-level assertions for the tile grid minimum extractor, bound to the top level.
// Depends on mgem_pkg and masked_grid_extract_min_unit_defines.svh.
`timescale 1ns / 1ps
`include "masked_grid_extract_min_unit_defines.svh"

module mgem_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_mode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input mgem_pkg::result_t rsp_payload
);
	import mgem_pkg::*;

	// A take keeps the request side busy while it scans
	`MGEM_ASSERT_NEXT(a_take_busy, clk, arst_n, req_valid && req_ready && (req_mode == MODE_TAKE), !req_ready, "request ready straight after a take transaction")

	// An empty result carries zero coordinates
	`MGEM_ASSERT_SAME(a_empty_zero, clk, arst_n, rsp_valid && rsp_payload.grid_empty, (rsp_payload.chosen_level == 1'b0) && (rsp_payload.chosen_row == 5'd0) && (rsp_payload.chosen_column == 4'd0), "empty result with non-zero coordinates")

	// A stalled result stays offered
	`MGEM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// A stalled result holds its payload
	`MGEM_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_payload), "result payload changed while stalled")

endmodule

bind masked_grid_extract_min_unit mgem_checker u_mgem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (request.valid),
	.req_ready  (request.ready),
	.req_mode   (request.payload.mode),
	.rsp_valid  (response.valid),
	.rsp_ready  (response.ready),
	.rsp_payload(response.payload)
);

### tb/tb_masked_grid_extract_min_unit.sv
// Self-checking testbench of masked_grid_extract_min_unit: loads and takes on the tile grid,
// checked against a scoreboard that tracks the grid. Depends on mgem_pkg, mgem_chan_if and
// the block itself.
`timescale 1ns / 1ps

module tb_masked_grid_extract_min_unit;
	import mgem_pkg::*;

	localparam int GL = GRID_LEVELS_DEF;
	localparam int GR = GRID_ROWS_DEF;
	localparam int GC = GRID_COLUMNS_DEF;

	// Register indexes outside the defined pair; the block ignores writes to them
	localparam logic [REG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [REG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int HOLD_CYCLES  = 600;
	localparam int LOAD_SETTLE  = 20;
	localparam int END_SETTLE   = 50;
	localparam int END_LIMIT    = 400000;
	localparam int PHASE_COUNT  = 20;
	localparam int PHASE_ITEMS  = 39;

	// Grid tracker: holds its own copy of the tiles and predicts each take
	class grid_scoreboard;
		bit                 movable_bits [GL][GR][GC];
		logic signed [15:0] rank_tbl [GL][GR][GC];
		logic [15:0]        near_tbl [GL][GR][GC];
		logic [COUNT_W-1:0] tiles_left;
		logic [REG_W-1:0]   scan_width;
		logic [REG_W-1:0]   scan_height;
		result_t            awaited_q[$];
		int                 fault_count;

		function new();
			tiles_left  = '0;
			scan_width  = MAP_WIDTH_RESET;
			scan_height = MAP_HEIGHT_RESET;
			fault_count = 0;
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction

		task report_fault(string what);
			fault_count++;
			if (fault_count <= 40)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		function void set_reg(logic [REG_INDEX_W-1:0] idx, logic [REG_W-1:0] data);
			case (idx)
				REG_MAP_WIDTH:  scan_width = data;
				REG_MAP_HEIGHT: scan_height = data;
				default: ;
			endcase
		endfunction

		// Apply a load, or predict the take's result and queue it
		function void note_request(request_t r);
			int lv, rw, cl, w, h, k, best, bl, br, bc;
			bit found, was;
			result_t e;
			if (r.mode == MODE_LOAD) begin
				lv = int'(r.tile_level);
				rw = int'(r.tile_row);
				cl = int'(r.tile_column);
				if (lv < GL && rw < GR && cl < GC) begin
					was = movable_bits[lv][rw][cl];
					rank_tbl[lv][rw][cl] = r.tile_rank;
					near_tbl[lv][rw][cl] = r.tile_nearness;
					if (r.tile_movable && !was)
						tiles_left = tiles_left + 1'b1;
					else if (!r.tile_movable && was)
						tiles_left = tiles_left - 1'b1;
					movable_bits[lv][rw][cl] = r.tile_movable;
				end
				return;
			end
			w = (int'(scan_width) < GC) ? int'(scan_width) : GC;
			h = (int'(scan_height) < GR) ? int'(scan_height) : GR;
			found = 0;
			best = 0;
			bl = 0;
			br = 0;
			bc = 0;
			for (lv = 0; lv < GL; lv++)
				for (rw = 0; rw < h; rw++)
					for (cl = 0; cl < w; cl++) begin
						if (!movable_bits[lv][rw][cl])
							continue;
						k = $signed({rank_tbl[lv][rw][cl], near_tbl[lv][rw][cl]});
						// later tile wins a tie
						if (!found || k <= best) begin
							found = 1;
							best = k;
							bl = lv;
							br = rw;
							bc = cl;
						end
					end
			if (found) begin
				movable_bits[bl][br][bc] = 0;
				tiles_left = tiles_left - 1'b1;
			end
			e.chosen_level    = bl[0];
			e.chosen_row      = br[4:0];
			e.chosen_column   = bc[3:0];
			e.remaining_count = tiles_left;
			e.grid_empty      = !found;
			awaited_q.push_back(e);
		endfunction

		task check_result(result_t got);
			result_t e;
			if (awaited_q.size() == 0) begin
				report_fault($sformatf("result %h with no take outstanding", got));
				return;
			end
			e = awaited_q.pop_front();
			if (got.chosen_level !== e.chosen_level)
				report_fault($sformatf("chosen_level %0d, want %0d",
					got.chosen_level, e.chosen_level));
			if (got.chosen_row !== e.chosen_row)
				report_fault($sformatf("chosen_row %0d, want %0d", got.chosen_row, e.chosen_row));
			if (got.chosen_column !== e.chosen_column)
				report_fault($sformatf("chosen_column %0d, want %0d",
					got.chosen_column, e.chosen_column));
			if (got.remaining_count !== e.remaining_count)
				report_fault($sformatf("remaining_count %0d, want %0d",
					got.remaining_count, e.remaining_count));
			if (got.grid_empty !== e.grid_empty)
				report_fault($sformatf("grid_empty %0b, want %0b", got.grid_empty, e.grid_empty));
		endtask

		task flush_leftovers();
			result_t e;
			while (awaited_q.size() > 0) begin
				e = awaited_q.pop_front();
				report_fault($sformatf("take result %h never arrived", e));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	mgem_chan_if #(.payload_t(request_t))    request_ch ();
	mgem_chan_if #(.payload_t(result_t))     response_ch ();
	mgem_chan_if #(.payload_t(regs_write_t)) regs_ch ();

	masked_grid_extract_min_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch),
		.regs     (regs_ch)
	);

	grid_scoreboard board;
	bit steady;
	bit hold_off_req;

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog
	initial begin
		#20000000;
		$display("masked_grid_extract_min_unit regression: fail");
		$finish;
	end

	// Gap length: mostly short, a few long, none in steady stretches
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// Offer one request transaction and note it once accepted; valid stays high
	task send_request(request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid   <= 1'b1;
		request_ch.payload <= r;
		do
			@(posedge clk);
		while (!request_ch.ready);
		board.note_request(r);
	endtask

	task load_tile(logic lvl, logic [4:0] row, logic [3:0] col, logic mov,
		logic signed [15:0] rank, logic [15:0] near);
		request_t r;
		r.mode          = MODE_LOAD;
		r.tile_level    = lvl;
		r.tile_row      = row;
		r.tile_column   = col;
		r.tile_movable  = mov;
		r.tile_rank     = rank;
		r.tile_nearness = near;
		send_request(r);
	endtask

	task take_tile();
		request_t r;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		r = raw[$bits(request_t)-1:0];
		r.mode = MODE_TAKE;
		send_request(r);
	endtask

	// Write one register; lower valid at acceptance and step past it
	task write_reg(logic [REG_INDEX_W-1:0] idx, logic [REG_W-1:0] data);
		regs_write_t wr;
		wr.index = idx;
		wr.data  = data;
		regs_ch.valid   <= 1'b1;
		regs_ch.payload <= wr;
		do
			@(posedge clk);
		while (!regs_ch.ready);
		board.set_reg(idx, data);
		regs_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every take to report, then let a trailing load finish
	task settle_idle();
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() > 0)
			@(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	task configure(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
		settle_idle();
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		if ($urandom_range(0, 3) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 5'($urandom));
	endtask

	// Random mix of loads and takes, loads biased into the scanned area
	task run_phase(int n_items, int take_pct, int w_cfg, int h_cfg);
		request_t r;
		logic [63:0] raw;
		int w_eff, h_eff, roll, v;
		w_eff = (w_cfg < GC) ? w_cfg : GC;
		h_eff = (h_cfg < GR) ? h_cfg : GR;
		for (int i = 0; i < n_items; i++) begin
			raw = {$urandom, $urandom};
			r = raw[$bits(request_t)-1:0];
			if ($urandom_range(0, 99) < take_pct) begin
				r.mode = MODE_TAKE;
			end else begin
				r.mode = MODE_LOAD;
				if (h_eff > 0 && $urandom_range(0, 9) < 8)
					r.tile_row = 5'($urandom_range(0, h_eff - 1));
				if (w_eff > 0 && $urandom_range(0, 9) < 8)
					r.tile_column = 4'($urandom_range(0, w_eff - 1));
				r.tile_movable = ($urandom_range(0, 99) < 85);
				// a narrow spread of keys provokes ties
				roll = $urandom_range(0, 9);
				if (roll < 3) begin
					v = int'($urandom_range(0, 2)) - 1;
					r.tile_rank = v[15:0];
				end else if (roll == 3) begin
					r.tile_rank = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
				end
				roll = $urandom_range(0, 9);
				if (roll < 3)
					r.tile_nearness = 16'($urandom_range(0, 3));
				else if (roll == 3)
					r.tile_nearness = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
			end
			send_request(r);
		end
	endtask

	// Check every response transaction
	always @(posedge clk) begin
		if (arst_n && response_ch.valid && response_ch.ready)
			board.check_result(response_ch.payload);
	end

	// Receiver: random ready, one long hold-off on request
	initial begin
		int on_len, off_len;
		response_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				response_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				response_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				on_len  = $urandom_range(1, 12);
				off_len = pick_gap();
				response_ch.ready <= 1'b1;
				repeat (on_len) @(posedge clk);
				if (off_len > 0) begin
					response_ch.ready <= 1'b0;
					repeat (off_len) @(posedge clk);
				end
			end
		end
	end

	// Main sequence
	initial begin
		int w_cfg, h_cfg, waited;
		int fixed_w [6];
		int fixed_h [6];
		fixed_w = '{0, 31, 1, 16, 17, 3};
		fixed_h = '{5, 31, 1, 18, 19, 0};
		board = new();
		steady = 0;
		hold_off_req = 0;
		arst_n = 1'b0;
		request_ch.valid   = 1'b0;
		request_ch.payload = '0;
		regs_ch.valid      = 1'b0;
		regs_ch.payload    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty grid, key extremes, ignored loads, ties, count tracking
		take_tile();
		load_tile(1'b1, 5'd17, 4'd15, 1'b1, 16'sh8000, 16'h0000);
		load_tile(1'b0, 5'd0, 4'd0, 1'b1, 16'sh7fff, 16'hffff);
		load_tile(1'b0, 5'd18, 4'd3, 1'b1, 16'sh0000, 16'h0000);
		load_tile(1'b1, 5'd31, 4'd7, 1'b1, 16'sh8000, 16'h0000);
		load_tile(1'b0, 5'd3, 4'd4, 1'b1, 16'sh0005, 16'h0007);
		load_tile(1'b1, 5'd2, 4'd1, 1'b1, 16'sh0005, 16'h0007);
		load_tile(1'b0, 5'd3, 4'd4, 1'b1, 16'sh0005, 16'h0007);
		load_tile(1'b0, 5'd9, 4'd9, 1'b1, 16'shffff, 16'hffff);
		load_tile(1'b0, 5'd9, 4'd9, 1'b0, 16'shffff, 16'hffff);
		load_tile(1'b1, 5'd5, 4'd5, 1'b0, 16'sh1234, 16'h5678);
		load_tile(1'b0, 5'd16, 4'd8, 1'b1, 16'sh0000, 16'h0000);
		repeat (6) take_tile();

		// Pressure: hold the receiver off while takes keep coming
		configure(5'd2, 5'd2);
		steady = 1;
		load_tile(1'b0, 5'd0, 4'd1, 1'b1, 16'sh0001, 16'h0002);
		load_tile(1'b1, 5'd1, 4'd0, 1'b1, 16'sh0001, 16'h0002);
		load_tile(1'b1, 5'd1, 4'd1, 1'b1, 16'shfff0, 16'h0002);
		hold_off_req = 1;
		while (hold_off_req)
			@(posedge clk);
		repeat (10) take_tile();
		steady = 0;

		// Random phases over a spread of scan areas
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p < 6) begin
				w_cfg = fixed_w[p];
				h_cfg = fixed_h[p];
			end else if ($urandom_range(0, 9) < 7) begin
				w_cfg = $urandom_range(1, 4);
				h_cfg = $urandom_range(1, 4);
			end else begin
				w_cfg = $urandom_range(0, 31);
				h_cfg = $urandom_range(0, 31);
			end
			configure(w_cfg[REG_W-1:0], h_cfg[REG_W-1:0]);
			steady = (p == 8 || p == 14);
			run_phase(PHASE_ITEMS, $urandom_range(15, 60), w_cfg, h_cfg);
			steady = 0;
		end

		// Drain
		request_ch.valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (board.pending() > 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (END_SETTLE) @(posedge clk);
		board.flush_leftovers();
		if (board.fault_count == 0)
			$display("masked_grid_extract_min_unit regression: pass");
		else
			$display("masked_grid_extract_min_unit regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/mgem_pkg.sv
hdl/mgem_chan_if.sv
hdl/mgem_tile_store.sv
hdl/mgem_scan_unit.sv
hdl/masked_grid_extract_min_unit.sv
hdl/mgem_checker.sv
tb/tb_masked_grid_extract_min_unit.sv
